FILE: src/iimp_pkg.sv
// ----------------------------------------------------------------------------
// iimp_pkg
// Types and constants shared by the IDE interface memory pager
// ----------------------------------------------------------------------------
package iimp_pkg;

  // request codes
  localparam logic [2:0] REQ_MEM_RD    = 3'd0;
  localparam logic [2:0] REQ_MEM_WR    = 3'd1;
  localparam logic [2:0] REQ_IO_RD     = 3'd2;
  localparam logic [2:0] REQ_IO_WR     = 3'd3;
  localparam logic [2:0] REQ_FETCH_PRE = 3'd4;
  localparam logic [2:0] REQ_FETCH_PST = 3'd5;

  // memory targets
  localparam logic [1:0] SPACE_NONE = 2'd0;
  localparam logic [1:0] SPACE_ROM  = 2'd1;
  localparam logic [1:0] SPACE_RAM  = 2'd2;

  // ide request codes
  localparam logic [1:0] IDE_NONE = 2'd0;
  localparam logic [1:0] IDE_RD   = 2'd1;
  localparam logic [1:0] IDE_WR   = 2'd2;

  // interface kinds
  localparam logic [1:0] KIND_ABSENT = 2'd0;
  localparam logic [1:0] KIND_PLAIN  = 2'd1;
  localparam logic [1:0] KIND_EXT    = 2'd2;

  // configuration register indexes
  localparam logic CFG_IDX_KIND = 1'b0;
  localparam logic CFG_IDX_48K  = 1'b1;

  // extended latch modes (top two bits)
  localparam logic [1:0] EXT_MODE_BANK = 2'b00;
  localparam logic [1:0] EXT_MODE_RAM  = 2'b01;
  localparam logic [1:0] EXT_MODE_ROM  = 2'b10;
  localparam logic [1:0] EXT_MODE_ALT  = 2'b11;

  // extended control commands (top three bits)
  localparam logic [2:0] EXT_CMD_128K  = 3'b001;
  localparam logic [2:0] EXT_CMD_RST0  = 3'b110;
  localparam logic [2:0] EXT_CMD_RST1  = 3'b111;

  // port and address constants
  localparam logic [7:0]  PORT_MASK     = 8'hE3;
  localparam logic [7:0]  PORT_IDE      = 8'hA3;
  localparam logic [7:0]  PORT_CTRL     = 8'hE3;
  localparam logic [7:0]  PORT_EXT      = 8'h17;
  localparam logic [7:0]  TRAP_PAGE     = 8'h3D;
  localparam logic [12:0] UNMAP_HI      = 13'h03FF;
  localparam logic [15:0] VEC_RESET     = 16'h0000;
  localparam logic [15:0] VEC_RST8      = 16'h0008;
  localparam logic [15:0] VEC_IM1       = 16'h0038;
  localparam logic [15:0] VEC_NMI       = 16'h0066;
  localparam logic [15:0] VEC_LOAD      = 16'h04C6;
  localparam logic [15:0] VEC_SAVE      = 16'h0562;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [15:0] ide_rdata;
    logic        rom_select;
  } iimp_in_t;

  typedef struct packed {
    logic [1:0]  mem_space;
    logic [18:0] mem_offset;
    logic        io_rvalid;
    logic [7:0]  io_rdata;
    logic [1:0]  ide_op;
    logic [2:0]  ide_reg;
    logic [15:0] ide_wdata;
    logic        is_mapped;
  } iimp_out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       host_48k;
  } iimp_cfg_t;

endpackage

FILE: src/iimp_mem_map.sv
// ----------------------------------------------------------------------------
// iimp_mem_map
// Translates a host memory access to an interface ROM or RAM offset
// ----------------------------------------------------------------------------
module iimp_mem_map (
  input  logic [1:0]  kind_i,
  input  logic [7:0]  ext_latch_i,
  input  logic [7:0]  ctrl_latch_i,
  input  logic [15:0] addr_i,
  input  logic        wr_i,
  output logic [1:0]  space_o,
  output logic [18:0] offset_o
);
  import iimp_pkg::*;

  logic [3:0]  bank;
  logic [12:0] low;
  logic [18:0] rom_off;
  logic        done;

  assign low = addr_i[12:0];

  always_comb begin
    bank     = 4'd0;
    done     = 1'b0;
    space_o  = SPACE_NONE;
    offset_o = '0;
    if (kind_i == KIND_EXT) begin
      unique case (ext_latch_i[7:6])
        EXT_MODE_BANK: bank = ext_latch_i[4:1];
        EXT_MODE_RAM: begin
          space_o  = SPACE_RAM;
          offset_o = {ext_latch_i[4:0], addr_i[13:0]};
          done     = 1'b1;
        end
        EXT_MODE_ROM: begin
          if (!wr_i) begin
            space_o  = SPACE_ROM;
            offset_o = {ext_latch_i[4:0], addr_i[13:0]};
          end
          done = 1'b1;
        end
        EXT_MODE_ALT: bank = 4'd0;
        default: bank = 4'd0;
      endcase
      rom_off = {bank, 2'b11, low};
    end else begin
      rom_off = {6'd0, low};
    end
    if (!done) begin
      priority if (addr_i[13]) begin
        space_o  = SPACE_RAM;
        offset_o = {bank, ctrl_latch_i[1:0], low};
      end else if (ctrl_latch_i[7]) begin
        if (!wr_i) begin
          space_o  = SPACE_ROM;
          offset_o = rom_off;
        end
      end else if (ctrl_latch_i[6]) begin
        if (!wr_i) begin
          space_o  = SPACE_RAM;
          offset_o = {bank, 2'b11, low};
        end
      end else begin
        space_o  = SPACE_ROM;
        offset_o = rom_off;
      end
    end
  end

endmodule

FILE: src/iimp_core.sv
// ----------------------------------------------------------------------------
// iimp_core
// Paging state, port decode, automap and IDE data pairing for one transaction
// ----------------------------------------------------------------------------
module iimp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  iimp_pkg::iimp_cfg_t cfg_i,
  input  iimp_pkg::iimp_in_t  item_i,
  output iimp_pkg::iimp_out_t res_o
);
  import iimp_pkg::*;

  logic [7:0] ctrl_q, ctrl_d;
  logic [7:0] ext_q, ext_d;
  logic       mapped_q, mapped_d;
  logic       odd_q, odd_d;
  logic [7:0] pair_q, pair_d;
  logic       m128_q, m128_d;

  logic        present;
  logic        ide_port;
  logic        ctrl_port;
  logic [2:0]  r;
  logic [1:0]  map_space;
  logic [18:0] map_off;
  logic        trap_ok;
  logic        vec_hit;

  assign present   = (cfg_i.kind == KIND_PLAIN) || (cfg_i.kind == KIND_EXT);
  assign ide_port  = (item_i.addr[7:0] & PORT_MASK) == PORT_IDE;
  assign ctrl_port = (item_i.addr[7:0] & PORT_MASK) == PORT_CTRL;
  assign r         = item_i.addr[4:2];
  assign trap_ok   = (ext_q[7:6] == EXT_MODE_BANK);
  assign vec_hit   = (item_i.addr == VEC_RESET) || (item_i.addr == VEC_RST8) ||
                     (item_i.addr == VEC_IM1) || (item_i.addr == VEC_NMI) ||
                     (item_i.addr == VEC_LOAD) || (item_i.addr == VEC_SAVE);

  iimp_mem_map u_mem_map (
    .kind_i      (cfg_i.kind),
    .ext_latch_i (ext_q),
    .ctrl_latch_i(ctrl_q),
    .addr_i      (item_i.addr),
    .wr_i        (item_i.req_type == REQ_MEM_WR),
    .space_o     (map_space),
    .offset_o    (map_off)
  );

  always_comb begin
    ctrl_d   = ctrl_q;
    ext_d    = ext_q;
    mapped_d = mapped_q;
    odd_d    = odd_q;
    pair_d   = pair_q;
    m128_d   = m128_q;
    res_o    = '0;
    unique case (item_i.req_type)
      REQ_MEM_RD, REQ_MEM_WR: begin
        if (present) begin
          res_o.mem_space  = map_space;
          res_o.mem_offset = map_off;
        end
      end
      REQ_IO_RD: begin
        if (present && ide_port) begin
          res_o.io_rvalid = 1'b1;
          priority if (r != 3'd0) begin
            odd_d          = 1'b1;
            res_o.io_rdata = item_i.ide_rdata[7:0];
            res_o.ide_op   = IDE_RD;
            res_o.ide_reg  = r;
          end else if (!odd_q) begin
            odd_d          = 1'b1;
            res_o.io_rdata = pair_q;
          end else begin
            pair_d         = item_i.ide_rdata[15:8];
            odd_d          = 1'b0;
            res_o.io_rdata = item_i.ide_rdata[7:0];
            res_o.ide_op   = IDE_RD;
          end
        end
      end
      REQ_IO_WR: begin
        if (present) begin
          if (ide_port) begin
            priority if (r != 3'd0) begin
              odd_d           = 1'b1;
              res_o.ide_op    = IDE_WR;
              res_o.ide_reg   = r;
              res_o.ide_wdata = {8'd0, item_i.wdata};
            end else if (odd_q) begin
              odd_d  = 1'b0;
              pair_d = item_i.wdata;
            end else begin
              res_o.ide_op    = IDE_WR;
              res_o.ide_wdata = {item_i.wdata, pair_q};
              odd_d           = 1'b0;
            end
          end
          if (ctrl_port) begin
            ctrl_d = item_i.wdata | (ctrl_q & 8'h40);
            if (item_i.wdata[7]) begin
              mapped_d = 1'b1;
            end
          end
          if (cfg_i.kind == KIND_EXT && item_i.addr[7:0] == PORT_EXT) begin
            ext_d = item_i.wdata;
            if (item_i.wdata[7:5] == EXT_CMD_RST0 || item_i.wdata[7:5] == EXT_CMD_RST1) begin
              ctrl_d   = 8'd0;
              ext_d    = 8'd0;
              mapped_d = 1'b0;
            end else if (item_i.wdata[7:5] == EXT_CMD_128K) begin
              m128_d = 1'b1;
            end
          end
        end
      end
      REQ_FETCH_PRE: begin
        if (trap_ok && item_i.addr[15:8] == TRAP_PAGE) begin
          if (cfg_i.kind == KIND_PLAIN) begin
            mapped_d = 1'b1;
          end else if (cfg_i.kind == KIND_EXT &&
                       (cfg_i.host_48k || !m128_q || item_i.rom_select)) begin
            mapped_d = 1'b1;
          end
        end
      end
      REQ_FETCH_PST: begin
        if (trap_ok && present) begin
          if (item_i.addr[15:3] == UNMAP_HI) begin
            mapped_d = 1'b0;
          end else if (vec_hit) begin
            mapped_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res_o.is_mapped = mapped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= 8'd0;
      ext_q    <= 8'd0;
      mapped_q <= 1'b0;
      odd_q    <= 1'b0;
      pair_q   <= 8'd0;
      m128_q   <= 1'b1;
    end else if (step_i) begin
      ctrl_q   <= ctrl_d;
      ext_q    <= ext_d;
      mapped_q <= mapped_d;
      odd_q    <= odd_d;
      pair_q   <= pair_d;
      m128_q   <= m128_d;
    end
  end

endmodule

FILE: src/ide_interface_memory_pager.sv
// path: an accepted transaction is held in the input register, decoded, and offered
// from the result register; output backpressure can hold it in the input register
// throughput: one transaction per cycle while the output is not held by backpressure,
// set by the single decode stage between the input register and the result register
// reset: asynchronous, latches and pairing state cleared, 128K mode enabled
// ----------------------------------------------------------------------------
// ide_interface_memory_pager
// Host bus memory pager and IDE register bridge
// ----------------------------------------------------------------------------
module ide_interface_memory_pager (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  iimp_pkg::iimp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output iimp_pkg::iimp_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [1:0]          cfg_data_i
);
  import iimp_pkg::*;

  iimp_cfg_t cfg_q;
  logic      in_valid_q;
  iimp_in_t  in_q;
  logic      out_valid_q;
  iimp_out_t out_q;
  iimp_out_t res;
  logic      step;

  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_KIND: cfg_q.kind     <= cfg_data_i;
        CFG_IDX_48K:  cfg_q.host_48k <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  iimp_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .cfg_i (cfg_q),
    .item_i(in_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_on_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  a_space_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.mem_space == SPACE_NONE ||
                     out_data_o.mem_space == SPACE_ROM ||
                     out_data_o.mem_space == SPACE_RAM))
    else $error("bad memory target code");

  a_ide_read_decoded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.ide_op == IDE_RD) |-> out_data_o.io_rvalid)
    else $error("ide read without decoded io read");

  a_result_follows_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("result lost after decode");
`endif

endmodule
